/* rtl/core/sdli_pkg.sv */
// Shared constants and the sine grid table for the degree sine interpolator.
// No dependencies.
package sdli_pkg;

  localparam int unsigned AngleW   = 9;
  localparam int unsigned FoldW    = 7;
  localparam int unsigned MagW     = 9;
  localparam int unsigned GridW    = 8;
  localparam int unsigned SpanW    = 6;
  localparam int unsigned OffW     = 3;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutUserW = 2;

  localparam logic [AngleW-1:0] Deg90  = 9'd90;
  localparam logic [AngleW-1:0] Deg180 = 9'd180;
  localparam logic [AngleW-1:0] Deg270 = 9'd270;
  localparam logic [AngleW-1:0] Deg360 = 9'd360;

  localparam logic [FoldW-1:0] Fold88 = 7'd88;
  localparam logic [FoldW-1:0] Fold89 = 7'd89;
  localparam logic [FoldW-1:0] Fold90 = 7'd90;

  localparam logic [MagW-1:0] MagOne  = 9'd256;
  localparam logic [MagW-1:0] Mag89   = 9'd255;
  localparam logic [MagW-1:0] Mag88   = 9'd254;

  // Sine in Q8 at 0, 8, 16, ... 88 degrees.
  function automatic logic [GridW-1:0] grid_pt(input logic [IdxW-1:0] idx);
    logic [GridW-1:0] v;
    case (idx)
      4'd0:    v = 8'd0;
      4'd1:    v = 8'd35;
      4'd2:    v = 8'd70;
      4'd3:    v = 8'd104;
      4'd4:    v = 8'd135;
      4'd5:    v = 8'd164;
      4'd6:    v = 8'd190;
      4'd7:    v = 8'd212;
      4'd8:    v = 8'd230;
      4'd9:    v = 8'd243;
      4'd10:   v = 8'd252;
      4'd11:   v = 8'd254;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/sdli_interp.sv */
// Linear step between two grid points: base + (off * span) / 8, truncated.
// Depends on sdli_pkg.
module sdli_interp (
  input  logic [sdli_pkg::GridW-1:0] base_i,
  input  logic [sdli_pkg::SpanW-1:0] span_i,
  input  logic [sdli_pkg::OffW-1:0]  off_i,
  output logic [sdli_pkg::MagW-1:0]  mag_o
);

  localparam int unsigned ProdW = sdli_pkg::SpanW + sdli_pkg::OffW;

  logic [ProdW-1:0] prod;

  assign prod  = {{sdli_pkg::SpanW{1'b0}}, off_i} * {{sdli_pkg::OffW{1'b0}}, span_i};
  // span * 7 stays below 256, so the sum fits in nine bits
  assign mag_o = {1'b0, base_i} + {3'b000, prod[ProdW-1:sdli_pkg::OffW]};

endmodule

/* rtl/core/sine_degree_lut_interpolator.sv */
// Top level of the degree sine interpolator: fold, table lookup, interpolate.
// Depends on sdli_pkg and sdli_interp.
// A word accepted into stage 1 moves on through stages 2 and 3 and is valid on
// the output while it is held in stage 3.
// Throughput: one word per cycle while the output is ready; three register stages,
// each holding a word while the output stalls, so nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
module sine_degree_lut_interpolator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side, tdata: [8:0] angle, [15:9] zero
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [sdli_pkg::InDataW-1:0]    s_axis_tdata_i,
  // master side, tdata: [8:0] magnitude, [15:9] zero
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [sdli_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // tuser: [0] negative, [1] out_of_range
  output logic [sdli_pkg::OutUserW-1:0]   m_axis_tuser_o
);

  // Stall chain: a stage takes a new word when it is empty or its word moves on.
  logic adv1, adv2, adv3;
  logic v1_q, v2_q, v3_q;

  assign adv3 = !v3_q || m_axis_tready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign s_axis_tready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: fold an in-range angle into 0..90 and decide sign and range.
  // ---------------------------------------------------------------------
  logic [sdli_pkg::AngleW-1:0] angle;
  logic [sdli_pkg::AngleW-1:0] fold_d;
  logic [sdli_pkg::FoldW-1:0]  q1_q;
  logic                        neg1_q, oor1_q;

  assign angle = s_axis_tdata_i[sdli_pkg::AngleW-1:0];

  always_comb begin
    if (angle <= sdli_pkg::Deg90) begin
      fold_d = angle;
    end else if (angle <= sdli_pkg::Deg180) begin
      fold_d = sdli_pkg::Deg180 - angle;
    end else if (angle <= sdli_pkg::Deg270) begin
      fold_d = angle - sdli_pkg::Deg180;
    end else begin
      // out of range angles wrap here; their magnitude is forced to 0 later
      fold_d = sdli_pkg::Deg360 - angle;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      q1_q   <= fold_d[sdli_pkg::FoldW-1:0];
      neg1_q <= (angle > sdli_pkg::Deg180);
      oor1_q <= (angle >= sdli_pkg::Deg360);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: grid lookup. Near 90 degrees the value comes straight out.
  // ---------------------------------------------------------------------
  logic [sdli_pkg::IdxW-1:0]  idx;
  logic [sdli_pkg::GridW-1:0] lo_pt, hi_pt;
  logic                       direct_d;
  logic [sdli_pkg::MagW-1:0]  dval_d;

  logic [sdli_pkg::GridW-1:0] base2_q;
  logic [sdli_pkg::SpanW-1:0] span2_q;
  logic [sdli_pkg::OffW-1:0]  off2_q;
  logic                       direct2_q;
  logic [sdli_pkg::MagW-1:0]  dval2_q;
  logic                       neg2_q, oor2_q;

  assign idx   = q1_q[sdli_pkg::FoldW-1:sdli_pkg::OffW];
  assign lo_pt = sdli_pkg::grid_pt(idx);
  assign hi_pt = sdli_pkg::grid_pt(idx + 4'd1);

  always_comb begin
    direct_d = 1'b1;
    if (q1_q >= sdli_pkg::Fold90) begin
      dval_d = sdli_pkg::MagOne;
    end else if (q1_q == sdli_pkg::Fold89) begin
      dval_d = sdli_pkg::Mag89;
    end else if (q1_q == sdli_pkg::Fold88) begin
      dval_d = sdli_pkg::Mag88;
    end else begin
      direct_d = 1'b0;
      dval_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      base2_q   <= lo_pt;
      // grid rises monotonically; the largest step is 35
      span2_q   <= sdli_pkg::SpanW'(hi_pt - lo_pt);
      off2_q    <= q1_q[sdli_pkg::OffW-1:0];
      direct2_q <= direct_d;
      dval2_q   <= dval_d;
      neg2_q    <= neg1_q;
      oor2_q    <= oor1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: interpolate, apply range override, hold for the output side.
  // ---------------------------------------------------------------------
  logic [sdli_pkg::MagW-1:0] interp_mag;
  logic [sdli_pkg::MagW-1:0] mag3_q;
  logic                      neg3_q, oor3_q;

  sdli_interp u_interp (
    .base_i (base2_q),
    .span_i (span2_q),
    .off_i  (off2_q),
    .mag_o  (interp_mag)
  );

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      if (oor2_q) begin
        mag3_q <= '0;
      end else if (direct2_q) begin
        mag3_q <= dval2_q;
      end else begin
        mag3_q <= interp_mag;
      end
      neg3_q <= neg2_q && !oor2_q;
      oor3_q <= oor2_q;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {{(sdli_pkg::OutDataW - sdli_pkg::MagW){1'b0}}, mag3_q};
  assign m_axis_tuser_o  = {oor3_q, neg3_q};

endmodule

/* rtl/core/sdli_checker.sv */
// Port-level checks for the degree sine interpolator, bound to the top level.
// Depends on sdli_pkg and sine_degree_lut_interpolator.
module sdli_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [sdli_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [sdli_pkg::OutUserW-1:0] m_axis_tuser_o
);

  // out of range words carry zero magnitude and no sign
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |->
      (m_axis_tdata_o == '0 && !m_axis_tuser_o[0]))
    else $error("out of range word with nonzero magnitude or sign");

  a_mag_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o <= sdli_pkg::OutDataW'(sdli_pkg::MagOne)))
    else $error("magnitude above 1.0");

  // an empty output stage means the whole pipe can take a word
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output empty");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled output word changed");

endmodule

bind sine_degree_lut_interpolator sdli_checker u_sdli_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* verif/tb_sine_degree_lut_interpolator.sv */
// Self-checking testbench for sine_degree_lut_interpolator: angle words in, sine words out.
// Depends on sdli_pkg and the interpolator RTL; its own table-based predictor checks each word.
module tb_sine_degree_lut_interpolator;

  localparam int unsigned MaxIdle      = 18;
  localparam int unsigned SettleCycles = 8;     // pipeline is 3 deep, leave slack
  localparam int unsigned RandomWords  = 800;
  localparam int unsigned FillWords    = 30;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned TimeoutUnits = 4_000_000;

  // Q8 sine at 0, 8, ... 88 degrees, used for interpolation
  localparam int unsigned SineGrid [12] = '{0, 35, 70, 104, 135, 164, 190, 212, 230, 243,
                                            252, 254};

  typedef struct packed {
    logic [sdli_pkg::MagW-1:0] magnitude;
    logic                      negative;
    logic                      out_of_range;
  } sine_word_t;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [sdli_pkg::InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [sdli_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic [sdli_pkg::OutUserW-1:0] m_axis_tuser_o;

  sine_word_t  pending_sines [$];
  int unsigned error_count      = 0;
  bit          send_idle_on     = 1'b0;
  bit          recv_idle_on     = 1'b0;
  int unsigned recv_hold_cycles = 0;

  sine_degree_lut_interpolator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Expected sine word for one angle: fold to the first quadrant, then
  // interpolate on the 8-degree grid or take the dedicated points at 88..90.
  function automatic sine_word_t predict_sine(input logic [sdli_pkg::AngleW-1:0] angle);
    sine_word_t  res;
    int unsigned q;
    int unsigned lo;
    int unsigned hi;
    res = '0;
    if (angle >= sdli_pkg::Deg360) begin
      // out of range: flag only, magnitude and sign forced low
      res.out_of_range = 1'b1;
      return res;
    end
    if (angle <= sdli_pkg::Deg90) begin
      q = 32'(angle);
    end else if (angle <= sdli_pkg::Deg180) begin
      q = 32'(sdli_pkg::Deg180 - angle);
    end else if (angle <= sdli_pkg::Deg270) begin
      q = 32'(angle - sdli_pkg::Deg180);
    end else begin
      q = 32'(sdli_pkg::Deg360 - angle);
    end
    res.negative = (angle > sdli_pkg::Deg180);    // 180 itself folds to 0 and stays positive
    if (q >= sdli_pkg::Fold90) begin
      res.magnitude = sdli_pkg::MagOne;
    end else if (q == sdli_pkg::Fold89) begin
      res.magnitude = sdli_pkg::Mag89;
    end else if (q == sdli_pkg::Fold88) begin
      res.magnitude = sdli_pkg::Mag88;
    end else begin
      lo = SineGrid[q / 8];
      hi = SineGrid[q / 8 + 1];
      res.magnitude = sdli_pkg::MagW'(lo + ((q % 8) * (hi - lo)) / 8);   // truncating divide
    end
    return res;
  endfunction

  // Offer one angle word, optionally after an idle gap; returns at the accepting edge.
  task automatic send_angle_word(input logic [sdli_pkg::InDataW-1:0] word);
    int unsigned wait_cycles;
    wait_cycles = send_idle_on ? $urandom_range(0, MaxIdle) : 0;
    @(negedge clk_i);
    if (wait_cycles != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (wait_cycles) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    pending_sines.push_back(predict_sine(word[sdli_pkg::AngleW-1:0]));
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Stop offering and let every expected sine word come out.
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_sines.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Quadrant edges, grid points, the 88..90 points, 180, out-of-range angles,
  // and junk in the padding bits above the angle.
  task automatic test_directed_corners();
    logic [sdli_pkg::InDataW-1:0] corner_words [24] = '{
      16'd0,   16'd1,   16'd7,   16'd8,   16'd45,  16'd80,  16'd87,  16'd88,
      16'd89,  16'd90,  16'd91,  16'd92,  16'd179, 16'd180, 16'd181, 16'd269,
      16'd270, 16'd271, 16'd359, 16'd360, 16'd361, 16'd511, 16'hFE1E, 16'hFFFF
    };
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    foreach (corner_words[i]) send_angle_word(corner_words[i]);
    wait_results_drained();
  endtask

  // Random angles in four stretches covering every idle combination of both sides.
  task automatic test_random_angles();
    logic [sdli_pkg::AngleW-1:0]  angle;
    logic [sdli_pkg::InDataW-1:0] word;
    int unsigned                  stretch;
    for (int unsigned i = 0; i < RandomWords; i++) begin
      stretch      = i / (RandomWords / 4);
      send_idle_on = stretch[0];
      recv_idle_on = stretch[1];
      // mostly valid angles, some past 359
      if ($urandom_range(0, 99) < 85) begin
        angle = sdli_pkg::AngleW'($urandom_range(0, 359));
      end else begin
        angle = sdli_pkg::AngleW'($urandom_range(360, 511));
      end
      word = {{(sdli_pkg::InDataW - sdli_pkg::AngleW){1'b0}}, angle};
      if ($urandom_range(0, 9) == 0) begin
        word[sdli_pkg::InDataW-1:sdli_pkg::AngleW] =
          (sdli_pkg::InDataW - sdli_pkg::AngleW)'($urandom);
      end
      send_angle_word(word);
    end
    wait_results_drained();
  endtask

  // Receiver holds off for a long stretch while words keep coming: the
  // pipeline fills and the input must stall without losing anything.
  task automatic test_backpressure_fill();
    send_idle_on     = 1'b0;
    recv_idle_on     = 1'b0;
    recv_hold_cycles = HoldCycles;
    for (int unsigned i = 0; i < FillWords; i++) begin
      send_angle_word(sdli_pkg::InDataW'($urandom_range(0, 511)));
    end
    wait_results_drained();
  endtask

  // Bursts separated by a full drain of the pipeline.
  task automatic test_sender_pause();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    for (int unsigned burst = 0; burst < 2; burst++) begin
      for (int unsigned i = 0; i < 16; i++) begin
        send_angle_word(sdli_pkg::InDataW'($urandom_range(0, 511)));
      end
      wait_results_drained();
    end
  endtask

  // Receiver: per output word draw a hold-off, or take a long one when requested.
  initial begin : drive_ready
    int unsigned wait_cycles;
    forever begin
      @(negedge clk_i);
      if (recv_hold_cycles != 0) begin
        wait_cycles      = recv_hold_cycles;
        recv_hold_cycles = 0;
      end else begin
        wait_cycles = recv_idle_on ? $urandom_range(0, MaxIdle) : 0;
      end
      if (wait_cycles != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Compare each accepted output word with the oldest expectation.
  always @(posedge clk_i) begin : check_outputs
    sine_word_t want;
    sine_word_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.magnitude    = m_axis_tdata_o[sdli_pkg::MagW-1:0];
      got.negative     = m_axis_tuser_o[0];
      got.out_of_range = m_axis_tuser_o[1];
      if (pending_sines.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual mag=%0d neg=%0b oor=%0b",
                 $time, got.magnitude, got.negative, got.out_of_range);
        error_count++;
      end else begin
        want = pending_sines.pop_front();
        if (got.magnitude !== want.magnitude) begin
          $display("%0t: magnitude expected %0d actual %0d",
                   $time, want.magnitude, got.magnitude);
          error_count++;
        end
        if (got.negative !== want.negative) begin
          $display("%0t: negative expected %0b actual %0b",
                   $time, want.negative, got.negative);
          error_count++;
        end
        if (got.out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range expected %0b actual %0b",
                   $time, want.out_of_range, got.out_of_range);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(TimeoutUnits);
    $display("tb_sine_degree_lut_interpolator: errors");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_corners();
    test_random_angles();
    test_backpressure_fill();
    test_sender_pause();
    if (error_count == 0) begin
      $display("tb_sine_degree_lut_interpolator: clean");
    end else begin
      $display("tb_sine_degree_lut_interpolator: errors");
    end
    $finish;
  end

endmodule

/* sine_degree_lut_interpolator.f */
rtl/core/sdli_pkg.sv
rtl/core/sdli_interp.sv
rtl/core/sine_degree_lut_interpolator.sv
rtl/core/sdli_checker.sv
verif/tb_sine_degree_lut_interpolator.sv
